/* design/smmc_pkg.sv */
// shared types and constants for the stone merge min cost unit
package smmc_pkg;

  // row capacity
  localparam int MAX_PILES = 16;

  // widths, most derived from capacity
  localparam int CNT_W = $clog2(MAX_PILES + 1);
  localparam int IDX_W = $clog2(MAX_PILES);
  localparam int W_W   = 16;
  localparam int PS_W  = W_W + CNT_W;
  localparam int CW    = 32;
  localparam int CT_AW = 2 * IDX_W;

  // result field widths
  localparam int OUT_COST_W = 24;
  localparam int OUT_CNT_W  = 5;
  localparam logic [CW-1:0] COST_MAX = CW'(24'hFFFFFF);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_WRITE,
    ST_DONE
  } state_e;

  // prefix sum memory request
  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] waddr;
    logic [PS_W-1:0]  wdata;
    logic             re;
    logic [CNT_W-1:0] raddr_hi;
    logic [CNT_W-1:0] raddr_lo;
  } ps_req_t;

  // cost table memory request
  typedef struct packed {
    logic             we;
    logic [CT_AW-1:0] waddr;
    logic [CW-1:0]    wdata;
    logic             re;
    logic [CT_AW-1:0] raddr_a;
    logic [CT_AW-1:0] raddr_b;
  } ct_req_t;

  // finished row result
  typedef struct packed {
    logic                  valid;
    logic [OUT_COST_W-1:0] cost;
    logic [OUT_CNT_W-1:0]  count;
    logic                  ovf;
  } res_t;

endpackage

/* design/smmc_ram.sv */
// generic memory, one write port and two registered read ports
module smmc_ram #(
  parameter int DW = 32,
  parameter int AW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, data held when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

/* design/smmc_ctrl.sv */
// row loader and interval sequencer with the shared add-compare unit
module smmc_ctrl
  import smmc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [W_W-1:0]  in_weight_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  logic            res_ready_i,
  output res_t            res_o,
  output ps_req_t         ps_req_o,
  input  logic [PS_W-1:0] ps_rdata_hi_i,
  input  logic [PS_W-1:0] ps_rdata_lo_i,
  output ct_req_t         ct_req_o,
  input  logic [CW-1:0]   ct_rdata_a_i,
  input  logic [CW-1:0]   ct_rdata_b_i
);

  state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, n_q, len_q;
  logic             drop_q, row_drop_q;
  logic [PS_W-1:0]  psum_q;
  logic [IDX_W-1:0] a_q, k_q, b_q;
  logic             v_q, first_q, adiag_q, bdiag_q, azero_q;
  logic [CW-1:0]    best_q, cost_q;

  logic             accept, keep, k_end, row_more, final_wr, issue;
  logic [CNT_W-1:0] n_new;
  logic [IDX_W-1:0] k_next;
  logic [PS_W-1:0]  span;
  logic [CW-1:0]    sum, wr_cost, a_val, b_val;

  assign accept   = in_valid_i && in_ready_o;
  assign keep     = cnt_q < CNT_W'(MAX_PILES);
  assign n_new    = keep ? cnt_q + 1'b1 : cnt_q;
  assign k_next   = k_q + 1'b1;
  assign k_end    = ({1'b0, k_q} + 1'b1) == {1'b0, b_q};
  assign row_more = (CNT_W'(b_q) + 1'b1) < n_q;
  assign final_wr = len_q == n_q;

  // span weight and new interval cost
  assign span    = ps_rdata_hi_i - (azero_q ? '0 : ps_rdata_lo_i);
  assign wr_cost = best_q + CW'(span);

  // sub-costs, diagonal entries read as zero
  assign a_val = adiag_q ? '0 : ct_rdata_a_i;
  assign b_val = bdiag_q ? '0 : ct_rdata_b_i;
  assign sum   = a_val + b_val;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_last_i) begin
          state_d = (n_new == CNT_W'(1)) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_WRITE;
      ST_WRITE: state_d = final_wr ? ST_DONE : ST_RUN;
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    res_o      = '0;
    ps_req_o   = '0;
    ct_req_o   = '0;
    ps_req_o.waddr    = cnt_q + 1'b1;
    ps_req_o.wdata    = psum_q + PS_W'(in_weight_i);
    ps_req_o.raddr_hi = CNT_W'(b_q) + 1'b1;
    ps_req_o.raddr_lo = CNT_W'(a_q);
    ct_req_o.waddr    = {a_q, b_q};
    ct_req_o.wdata    = wr_cost;
    ct_req_o.raddr_a  = {a_q, k_q};
    ct_req_o.raddr_b  = {k_next, b_q};
    res_o.cost  = (cost_q > COST_MAX) ? OUT_COST_W'(COST_MAX) : cost_q[OUT_COST_W-1:0];
    res_o.count = OUT_CNT_W'(n_q);
    res_o.ovf   = row_drop_q || (cost_q > COST_MAX);
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ps_req_o.we = in_valid_i && keep;
      end
      ST_RUN: begin
        issue       = 1'b1;
        ct_req_o.re = 1'b1;
        ps_req_o.re = k_q == a_q;
      end
      ST_WRITE: ct_req_o.we = 1'b1;
      ST_DONE:  res_o.valid = 1'b1;
      default: ;
    endcase
  end

  // state and sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      drop_q     <= 1'b0;
      psum_q     <= '0;
      n_q        <= '0;
      row_drop_q <= 1'b0;
      len_q      <= '0;
      a_q        <= '0;
      k_q        <= '0;
      b_q        <= '0;
      cost_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_last_i) begin
              cnt_q      <= '0;
              drop_q     <= 1'b0;
              psum_q     <= '0;
              n_q        <= n_new;
              row_drop_q <= drop_q || !keep;
              len_q      <= CNT_W'(2);
              a_q        <= '0;
              k_q        <= '0;
              b_q        <= IDX_W'(1);
              cost_q     <= '0;
            end else if (keep) begin
              cnt_q  <= n_new;
              psum_q <= ps_req_o.wdata;
            end else begin
              drop_q <= 1'b1;
            end
          end
        end
        ST_RUN: begin
          if (!k_end) k_q <= k_next;
        end
        ST_WRITE: begin
          if (final_wr) begin
            cost_q <= wr_cost;
          end else if (row_more) begin
            a_q <= a_q + 1'b1;
            k_q <= a_q + 1'b1;
            b_q <= b_q + 1'b1;
          end else begin
            len_q <= len_q + 1'b1;
            a_q   <= '0;
            k_q   <= '0;
            b_q   <= IDX_W'(len_q);
          end
        end
        default: ;
      endcase
    end
  end

  // read tracking for the add-compare stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= issue;
    end
  end

  // flags that travel with each read
  always_ff @(posedge clk_i) begin
    if (issue) begin
      first_q <= k_q == a_q;
      adiag_q <= k_q == a_q;
      bdiag_q <= k_next == b_q;
    end
    if (ps_req_o.re) begin
      azero_q <= a_q == '0;
    end
  end

  // running minimum over split points
  always_ff @(posedge clk_i) begin
    if (v_q) begin
      if (first_q || (sum < best_q)) begin
        best_q <= sum;
      end
    end
  end

endmodule

/* design/stone_merge_min_cost_unit.sv */
// top level: stream ports, memories, sequencer and result register
//
// Takes a row of pile weights on the slave stream, one beat per pile, with
// tlast on the final pile, and returns one beat per row on the master
// stream: minimum total merge cost (saturating), pile count and an
// overflow flag. Piles beyond capacity are dropped and flagged.
// Each pile beat is taken as soon as it is offered. After the last pile
// the sequencer fills the interval table one interval at a time, each
// by a scan over its split points, bound by the single add-compare unit
// and the two read ports of the cost table memory.
// The slave side is not ready while a row is being solved.
// A finished result sits in an output register, so a new row can load
// while the receiver stalls; the next result waits until that register
// is free. Reset clears the row count, drop flag and output valid; the
// memories need no clearing.
module stone_merge_min_cost_unit
  import smmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // pile_weight[15:0]
  input  logic        s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // total_cost[23:0], pile_count[28:24], zeros
  output logic        m_axis_tuser_o    // overflow
);

  res_t            res;
  logic            res_ready;
  ps_req_t         ps_req;
  ct_req_t         ct_req;
  logic [PS_W-1:0] ps_rdata_hi, ps_rdata_lo;
  logic [CW-1:0]   ct_rdata_a, ct_rdata_b;
  logic            out_valid_q;
  logic [31:0]     out_data_q;
  logic            out_user_q;

  // sequencer
  smmc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_weight_i   (s_axis_tdata_i[W_W-1:0]),
    .in_last_i     (s_axis_tlast_i),
    .in_ready_o    (s_axis_tready_o),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .ps_req_o      (ps_req),
    .ps_rdata_hi_i (ps_rdata_hi),
    .ps_rdata_lo_i (ps_rdata_lo),
    .ct_req_o      (ct_req),
    .ct_rdata_a_i  (ct_rdata_a),
    .ct_rdata_b_i  (ct_rdata_b)
  );

  // prefix sums
  smmc_ram #(.DW(PS_W), .AW(CNT_W)) u_ps_ram (
    .clk_i     (clk_i),
    .we_i      (ps_req.we),
    .waddr_i   (ps_req.waddr),
    .wdata_i   (ps_req.wdata),
    .re_i      (ps_req.re),
    .raddr_a_i (ps_req.raddr_hi),
    .raddr_b_i (ps_req.raddr_lo),
    .rdata_a_o (ps_rdata_hi),
    .rdata_b_o (ps_rdata_lo)
  );

  // interval cost table
  smmc_ram #(.DW(CW), .AW(CT_AW)) u_ct_ram (
    .clk_i     (clk_i),
    .we_i      (ct_req.we),
    .waddr_i   (ct_req.waddr),
    .wdata_i   (ct_req.wdata),
    .re_i      (ct_req.re),
    .raddr_a_i (ct_req.raddr_a),
    .raddr_b_i (ct_req.raddr_b),
    .rdata_a_o (ct_rdata_a),
    .rdata_b_o (ct_rdata_b)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_data_q <= 32'({res.count, res.cost});
      out_user_q <= res.ovf;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // a marked pile starts the solve, so the slave side closes
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("slave side still ready after last pile");

  // a taken beat with no new result empties the output register
  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !res.valid) |=> !m_axis_tvalid_o)
    else $error("output beat repeated");

  // a pending result never coexists with loading
  a_res_not_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !s_axis_tready_o)
    else $error("result pending while loading piles");

endmodule
